// File: rtl/mpsq_pkg.sv
// Package for the masked pending signal queue.
// Holds the record type, result kinds, sequencer states and sizing constants.
// Used by mpsq_cell and masked_pending_signal_queue_top.
package mpsq_pkg;

  localparam int unsigned QUEUE_SLOTS = 32;
  // One ring slot is always kept free, so the chain holds one record less.
  localparam int unsigned NUM_CELLS   = QUEUE_SLOTS - 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_SLOTS);

  typedef struct packed {
    logic        [6:0]  signo;
    logic signed [31:0] code;
    logic signed [31:0] pid;
    logic signed [31:0] uid;
    logic signed [31:0] status;
    logic        [63:0] address;
    logic signed [63:0] payload;
  } rec_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    KIND_DELIVER  = 3'd0,
    KIND_RERAISE  = 3'd1,
    KIND_NONE     = 3'd2,
    KIND_CAPTURED = 3'd3,
    KIND_DROPPED  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_POLL    = 1'b1;

  // Mask bit of a signal number: (signo - 1) modulo 64.
  function automatic logic [5:0] sig_bit(input logic [6:0] signo);
    return signo[5:0] - 6'd1;
  endfunction

endpackage

// File: rtl/mpsq_cell.sv
// One cell of the record chain: holds a single queued record.
// Each cycle it keeps its record, takes its neighbor's, or loads a new one.
// Depends on mpsq_pkg.
module mpsq_cell
  import mpsq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       nbr_i,
  input  rec_t       new_i,
  output rec_t       rec_o
);

  rec_t rec_q;

  // A load wins over a shift: the tail cell of a rotation takes the head record.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rec_q <= new_i;
    end else if (ctrl_i.shift) begin
      rec_q <= nbr_i;
    end
  end

  assign rec_o = rec_q;

endmodule

// File: rtl/masked_pending_signal_queue_top.sv
// Top level of the masked pending signal queue.
// Holds the cell chain, the poll sequencer and the registered result stage.
// Depends on mpsq_pkg and mpsq_cell.

// A capture item gives one result (captured, or dropped when 31 records are
// queued). A poll item, once accepted, walks the whole chain once, one record
// per cycle through the head cell unless the output side stalls, and then takes
// one closing step. Blocked records, and all records after a delivered one, are
// rotated to the tail so the queue order is kept. A new item is taken only when
// the walk is done and the result register can accept a result.
module masked_pending_signal_queue_top
  import mpsq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic        [6:0]  signo_i,
  input  logic signed [31:0] info_code_i,
  input  logic signed [31:0] sender_pid_i,
  input  logic signed [31:0] sender_uid_i,
  input  logic signed [31:0] child_status_i,
  input  logic        [63:0] fault_address_i,
  input  logic signed [63:0] payload_i,
  input  logic        [63:0] blocked_mask_i,
  input  logic        [63:0] ignore_mask_i,
  input  logic        [63:0] default_mask_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [2:0]  kind_o,
  output logic        [6:0]  out_signo_o,
  output logic signed [31:0] out_code_o,
  output logic signed [31:0] out_pid_o,
  output logic signed [31:0] out_uid_o,
  output logic signed [31:0] out_status_o,
  output logic        [63:0] out_address_o,
  output logic signed [63:0] out_payload_o,
  output logic               pending_o,
  output logic               last_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  logic              stopped_q, stopped_d;
  logic [63:0]       blocked_q, ignore_q, default_q;

  logic              out_valid_q;
  kind_e             kind_q;
  rec_t              out_rec_q;
  logic              pending_q, last_q;

  rec_t              cell_rec [NUM_CELLS];
  rec_t              cell_nbr [NUM_CELLS];
  cell_ctrl_t        cell_ctrl [NUM_CELLS];

  rec_t              in_rec, new_rec, head_rec;
  logic              out_free, in_accept;
  logic              shift_all, load_en;
  logic [CNT_W-1:0]  load_idx;
  logic              emit, emit_rec, emit_pending, emit_last;
  kind_e             emit_kind;
  logic              head_blocked, head_ignored, head_default;

  assign in_rec = '{signo: signo_i, code: info_code_i, pid: sender_pid_i,
                    uid: sender_uid_i, status: child_status_i,
                    address: fault_address_i, payload: payload_i};

  assign head_rec     = cell_rec[0];
  assign head_blocked = blocked_q[sig_bit(head_rec.signo)];
  assign head_ignored = ignore_q[sig_bit(head_rec.signo)];
  assign head_default = default_q[sig_bit(head_rec.signo)];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign new_rec    = (state_q == ST_IDLE) ? in_rec : head_rec;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    steps_d      = steps_q;
    stopped_d    = stopped_q;
    shift_all    = 1'b0;
    load_en      = 1'b0;
    load_idx     = count_q;
    emit         = 1'b0;
    emit_kind    = KIND_NONE;
    emit_rec     = 1'b0;
    emit_pending = count_q != '0;
    emit_last    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (op_i == OP_CAPTURE) begin
            emit = 1'b1;
            if (count_q == CNT_W'(NUM_CELLS)) begin
              emit_kind = KIND_DROPPED;
            end else begin
              emit_kind    = KIND_CAPTURED;
              emit_pending = 1'b1;
              load_en      = 1'b1;
              count_d      = count_q + CNT_W'(1);
            end
          end else begin
            steps_d   = count_q;
            stopped_d = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (steps_q == '0) begin
          if (stopped_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            emit      = 1'b1;
            emit_kind = KIND_NONE;
            state_d   = ST_IDLE;
          end
        end else if (head_blocked || stopped_q) begin
          // Keep the record: rotate it from the head to the tail.
          shift_all = 1'b1;
          load_en   = 1'b1;
          load_idx  = count_q - CNT_W'(1);
          steps_d   = steps_q - CNT_W'(1);
        end else if (head_ignored) begin
          shift_all = 1'b1;
          count_d   = count_q - CNT_W'(1);
          steps_d   = steps_q - CNT_W'(1);
        end else if (out_free) begin
          shift_all    = 1'b1;
          count_d      = count_q - CNT_W'(1);
          steps_d      = steps_q - CNT_W'(1);
          emit         = 1'b1;
          emit_rec     = 1'b1;
          emit_pending = count_q != CNT_W'(1);
          if (head_default) begin
            emit_kind = KIND_RERAISE;
            emit_last = 1'b0;
          end else begin
            emit_kind = KIND_DELIVER;
            stopped_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      steps_q     <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      steps_q   <= steps_d;
      stopped_q <= stopped_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && op_i == OP_POLL) begin
      blocked_q <= blocked_mask_i;
      ignore_q  <= ignore_mask_i;
      default_q <= default_mask_i;
    end
    if (emit) begin
      kind_q    <= emit_kind;
      out_rec_q <= emit_rec ? head_rec : '0;
      pending_q <= emit_pending;
      last_q    <= emit_last;
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == NUM_CELLS - 1) begin : g_tail
      assign cell_nbr[i] = '0;
    end else begin : g_body
      assign cell_nbr[i] = cell_rec[i+1];
    end
    assign cell_ctrl[i] = '{shift: shift_all,
                            load: load_en && (load_idx == CNT_W'(i))};
    mpsq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .nbr_i  (cell_nbr[i]),
      .new_i  (new_rec),
      .rec_o  (cell_rec[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_signo_o   = out_rec_q.signo;
  assign out_code_o    = out_rec_q.code;
  assign out_pid_o     = out_rec_q.pid;
  assign out_uid_o     = out_rec_q.uid;
  assign out_status_o  = out_rec_q.status;
  assign out_address_o = out_rec_q.address;
  assign out_payload_o = out_rec_q.payload;
  assign pending_o     = pending_q;
  assign last_o        = last_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NUM_CELLS))
    else $error("queue count exceeds capacity");

  a_steps_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> steps_q <= count_q)
    else $error("scan steps exceed queued records");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op_i == OP_CAPTURE && count_q == CNT_W'(NUM_CELLS)
    |=> out_valid_o && kind_o == KIND_DROPPED && count_q == CNT_W'(NUM_CELLS))
    else $error("capture into full queue not dropped");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("item accepted while a poll is running");

endmodule

// File: tb/masked_pending_signal_queue_top_test.sv
// Self-checking testbench for masked_pending_signal_queue_top.
// Drives capture and poll items, predicts the signal queue and compares results.
// Depends on mpsq_pkg and the RTL of the queue.
module masked_pending_signal_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mpsq_pkg::*;

  typedef struct {
    logic        op;
    logic [6:0]  signo;
    logic [31:0] code, pid, uid, status;
    logic [63:0] address, payload, blocked, ignored, dflt;
  } sig_item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [6:0]  signo;
    logic [31:0] code, pid, uid, status;
    logic [63:0] address, payload;
    logic        pending, last;
  } sig_result_t;

  typedef struct {
    logic        op;
    logic [6:0]  signo;
    logic [63:0] blocked, ignored, dflt;
    logic        fixed;
    kind_e       kind;
  } dir_row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic op_i = 1'b0;
  logic [6:0] signo_i = '0;
  logic signed [31:0] info_code_i = '0, sender_pid_i = '0, sender_uid_i = '0;
  logic signed [31:0] child_status_i = '0;
  logic [63:0] fault_address_i = '0, blocked_mask_i = '0, ignore_mask_i = '0;
  logic [63:0] default_mask_i = '0;
  logic signed [63:0] payload_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [6:0] out_signo_o;
  logic signed [31:0] out_code_o, out_pid_o, out_uid_o, out_status_o;
  logic [63:0] out_address_o;
  logic signed [63:0] out_payload_o;
  logic pending_o, last_o;

  masked_pending_signal_queue_top dut (.*);

  // Predicted queue contents, oldest first.
  sig_item_t   pending_recs[$];
  sig_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mask_bit(logic [6:0] s);
    return 64'd1 << ((s + 7'd63) & 7'd63);
  endfunction

  function automatic sig_result_t make_result(kind_e k, sig_item_t r, bit with_rec,
                                              bit lst);
    sig_result_t x;
    x = '{default: '0};
    x.kind = k;
    if (with_rec) begin
      x.signo = r.signo; x.code = r.code; x.pid = r.pid; x.uid = r.uid;
      x.status = r.status; x.address = r.address; x.payload = r.payload;
    end
    x.pending = pending_recs.size() != 0;
    x.last = lst;
    return x;
  endfunction

  task automatic predict_queue(sig_item_t it);
    sig_item_t r;
    int idx;
    bit found;
    if (it.op == OP_CAPTURE) begin
      if (pending_recs.size() == NUM_CELLS) begin
        expected_results.push_back(make_result(KIND_DROPPED, it, 0, 1));
      end else begin
        pending_recs.push_back(it);
        expected_results.push_back(make_result(KIND_CAPTURED, it, 0, 1));
      end
      return;
    end
    forever begin
      found = 0;
      foreach (pending_recs[i]) begin
        if (!found && (it.blocked & mask_bit(pending_recs[i].signo)) == 0) begin
          found = 1; idx = i;
        end
      end
      if (!found) break;
      r = pending_recs[idx];
      pending_recs.delete(idx);
      if (it.ignored & mask_bit(r.signo)) continue;
      if (it.dflt & mask_bit(r.signo)) begin
        expected_results.push_back(make_result(KIND_RERAISE, r, 1, 0));
        continue;
      end
      expected_results.push_back(make_result(KIND_DELIVER, r, 1, 1));
      return;
    end
    expected_results.push_back(make_result(KIND_NONE, it, 0, 1));
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Drive one item and wait for it to be accepted.
  task automatic send_item(sig_item_t it);
    op_i = it.op; signo_i = it.signo; info_code_i = it.code; sender_pid_i = it.pid;
    sender_uid_i = it.uid; child_status_i = it.status; fault_address_i = it.address;
    payload_i = it.payload; blocked_mask_i = it.blocked; ignore_mask_i = it.ignored;
    default_mask_i = it.dflt;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_queue(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic sig_item_t rand_item(bit op, logic [6:0] s);
    sig_item_t it;
    it.op = op; it.signo = s;
    it.code = $urandom; it.pid = $urandom; it.uid = $urandom; it.status = $urandom;
    it.address = {$urandom, $urandom}; it.payload = {$urandom, $urandom};
    it.blocked = '0; it.ignored = '0; it.dflt = '0;
    return it;
  endfunction

  function automatic logic [63:0] rand_mask(int density);
    logic [63:0] m;
    for (int b = 0; b < 64; b++) m[b] = $urandom_range(99, 0) < density;
    return m;
  endfunction

  // Result checking.
  always @(posedge clk_i) begin
    sig_result_t e;
    cycles++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(kind_o), 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (kind_o !== e.kind) report_mismatch("kind", 64'(kind_o), 64'(e.kind));
        if (out_signo_o !== e.signo)
          report_mismatch("signo", 64'(out_signo_o), 64'(e.signo));
        if (out_code_o !== e.code) report_mismatch("code", 64'(out_code_o), 64'(e.code));
        if (out_pid_o !== e.pid) report_mismatch("pid", 64'(out_pid_o), 64'(e.pid));
        if (out_uid_o !== e.uid) report_mismatch("uid", 64'(out_uid_o), 64'(e.uid));
        if (out_status_o !== e.status)
          report_mismatch("status", 64'(out_status_o), 64'(e.status));
        if (out_address_o !== e.address) report_mismatch("address", out_address_o, e.address);
        if (out_payload_o !== e.payload) report_mismatch("payload", out_payload_o, e.payload);
        if (pending_o !== e.pending)
          report_mismatch("pending", 64'(pending_o), 64'(e.pending));
        if (last_o !== e.last) report_mismatch("last", 64'(last_o), 64'(e.last));
      end
    end
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: stalls on its own pattern, with one long hold-off that it times itself.
  initial begin
    int phase;
    int hold_left;
    bit held;
    phase = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_off && !held) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end
      else if ((phase / 200) % 2 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= $urandom_range(3, 0) != 0;
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    sig_item_t it;
    int burst, kind_sel;
    dir_rows = '{
      '{OP_POLL, 7'd1, 64'd0, 64'd0, 64'd0, 1'b1, KIND_NONE},
      '{OP_CAPTURE, 7'd1, 64'd0, 64'd0, 64'd0, 1'b1, KIND_CAPTURED},
      '{OP_CAPTURE, 7'd64, 64'd0, 64'd0, 64'd0, 1'b1, KIND_CAPTURED},
      '{OP_CAPTURE, 7'd0, 64'd0, 64'd0, 64'd0, 1'b1, KIND_CAPTURED},
      '{OP_CAPTURE, 7'd127, 64'd0, 64'd0, 64'd0, 1'b1, KIND_CAPTURED},
      '{OP_CAPTURE, 7'd65, 64'd0, 64'd0, 64'd0, 1'b1, KIND_CAPTURED},
      // Signals 1 and 65 blocked; signals 64 and zero both ignored and default.
      '{OP_POLL, 7'd0, 64'd1, {1'b1, 63'd0}, {1'b1, 63'd0}, 1'b0, KIND_NONE},
      '{OP_POLL, 7'd0, '1, 64'd0, 64'd0, 1'b1, KIND_NONE},
      '{OP_POLL, 7'd0, 64'd0, 64'd0, '1, 1'b0, KIND_NONE},
      '{OP_POLL, 7'd0, 64'd0, 64'd0, 64'd0, 1'b1, KIND_NONE},
      '{OP_CAPTURE, 7'd5, 64'd0, 64'd0, 64'd0, 1'b1, KIND_CAPTURED},
      '{OP_POLL, 7'd0, 64'd0, 64'd0, 64'd0, 1'b1, KIND_DELIVER},
      '{OP_POLL, 7'd0, 64'd0, '1, '1, 1'b1, KIND_NONE}
    };
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_rows[i]) begin
      it = rand_item(dir_rows[i].op, dir_rows[i].signo);
      if (i == 1) begin
        it.code = 32'h8000_0000; it.pid = 32'h7fff_ffff; it.uid = '1; it.status = '0;
        it.address = '1; it.payload = 64'h8000_0000_0000_0000;
      end
      it.blocked = dir_rows[i].blocked; it.ignored = dir_rows[i].ignored;
      it.dflt = dir_rows[i].dflt;
      send_item(it);
      if (dir_rows[i].fixed && expected_results[$].kind !== dir_rows[i].kind)
        report_mismatch("table kind", 64'(expected_results[$].kind),
                        64'(dir_rows[i].kind));
    end
    // Fill past capacity while the receiver holds off, so the input stalls.
    hold_off = 1'b1;
    for (int i = 0; i < 34; i++)
      send_item(rand_item(OP_CAPTURE, 7'($urandom_range(64, 1))));
    hold_off = 1'b0;
    // Random bursts: mostly captures of small signal sets and masked polls.
    for (int n = 0; n < 300; ) begin
      burst = $urandom_range(8, 1);
      for (int b = 0; b < burst; b++, n++) begin
        kind_sel = $urandom_range(9, 0);
        if (kind_sel < 6) begin
          it = rand_item(OP_CAPTURE, kind_sel == 0 ? 7'($urandom_range(127, 0))
                                                   : 7'($urandom_range(8, 1)));
        end else begin
          it = rand_item(OP_POLL, 7'($urandom));
          it.code = $urandom; it.address = {$urandom, $urandom};
          it.blocked = $urandom_range(1, 0) ? rand_mask(30) : rand_mask(90);
          it.ignored = rand_mask(15);
          it.dflt = rand_mask(40);
        end
        send_item(it);
      end
      repeat ($urandom_range(6, 0)) @(negedge clk_i);
    end
    // Drain: one poll with nothing blocked and every signal default empties the queue.
    it = rand_item(OP_POLL, 7'd1);
    it.dflt = '1;
    send_item(it);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
